// ----- rtl/core/gf2_47_multiply_invert_macros.svh -----
// assertion macros, clocked on clk and disabled while arst_n is low
`ifndef GF2_47_MULTIPLY_INVERT_MACROS_SVH
`define GF2_47_MULTIPLY_INVERT_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define GF47_ASSERT_NOW(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error("assertion failed");

// condition in this cycle implies consequence in the next cycle
`define GF47_ASSERT_NEXT(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error("assertion failed");

`endif

// ----- rtl/core/gf47_pkg.sv -----
`default_nettype none
package gf47_pkg;
	localparam int FIELD_W = 47;
	localparam logic [FIELD_W-1:0] FOLD = 47'h21;
	localparam int NUM_ROUNDS = 8;
	// addition chain 1,2,4,5,10,11,22,23,46
	localparam int ROUND_SQ [NUM_ROUNDS] = '{1, 2, 1, 5, 1, 11, 1, 23};
	localparam bit ROUND_USE_A [NUM_ROUNDS] = '{0, 0, 1, 0, 1, 0, 1, 0};

	typedef enum logic {
		REQ_MUL = 1'b0,
		REQ_INV = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic inv;
		logic act;
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] t;
		logic [FIELD_W-1:0] s;
		logic [FIELD_W-1:0] m;
		logic [FIELD_W-1:0] acc;
	} stage_t;

	function automatic logic [FIELD_W-1:0] gf_times_x(input logic [FIELD_W-1:0] v);
		logic [FIELD_W-1:0] r;
		r = {v[FIELD_W-2:0], 1'b0};
		if (v[FIELD_W-1]) begin
			r = r ^ FOLD;
		end
		return r;
	endfunction

	function automatic logic [FIELD_W-1:0] gf_reduce(input logic [2*FIELD_W-2:0] c);
		logic [50:0] f;
		logic [FIELD_W-1:0] r;
		f = {4'b0, c[46:0]} ^ {5'b0, c[92:47]} ^ {c[92:47], 5'b0};
		r = f[46:0] ^ {43'b0, f[50:47]} ^ {38'b0, f[50:47], 5'b0};
		return r;
	endfunction

	function automatic logic [FIELD_W-1:0] gf_sq(input logic [FIELD_W-1:0] v);
		logic [2*FIELD_W-2:0] c;
		c = '0;
		for (int i = 0; i < FIELD_W; i++) begin
			c[2*i] = v[i];
		end
		return gf_reduce(c);
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/gf47_if.sv -----
`default_nettype none
interface gf47_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [46:0] operand_a;
	logic [46:0] operand_b;
	modport source (output valid, output req_type, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input req_type, input operand_a, input operand_b,
		output ready);
endinterface

interface gf47_res_if;
	logic valid;
	logic ready;
	logic [46:0] field_result;
	modport source (output valid, output field_result, input ready);
	modport sink (input valid, input field_result, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/gf47_sq_cell.sv -----
`default_nettype none
module gf47_sq_cell import gf47_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   in_v,
	input  wire stage_t in_d,
	output logic        out_v,
	output stage_t      out_d
);
	logic   v_q;
	stage_t d_q;
	stage_t d_nxt;

	always_comb begin
		d_nxt = in_d;
		if (in_d.inv) begin
			d_nxt.s = gf_sq(in_d.s);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= d_nxt;
		end
	end

	assign out_v = v_q;
	assign out_d = d_q;
endmodule
`default_nettype wire

// ----- rtl/core/gf47_mul_cell.sv -----
`default_nettype none
module gf47_mul_cell import gf47_pkg::*; #(
	parameter int BIT = FIELD_W - 1
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   in_v,
	input  wire stage_t in_d,
	output logic        out_v,
	output stage_t      out_d
);
	logic   v_q;
	stage_t d_q;
	stage_t d_nxt;

	always_comb begin
		d_nxt = in_d;
		if (in_d.act) begin
			d_nxt.acc = gf_times_x(in_d.acc) ^ (in_d.m[BIT] ? in_d.s : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= d_nxt;
		end
	end

	assign out_v = v_q;
	assign out_d = d_q;
endmodule
`default_nettype wire

// ----- rtl/core/gf47_round.sv -----
`default_nettype none
module gf47_round import gf47_pkg::*; #(
	parameter int NSQ   = 1,
	parameter bit USE_A = 1'b0,
	parameter bit FIRST = 1'b0
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   in_v,
	input  wire stage_t in_d,
	output logic        out_v,
	output stage_t      out_d
);
	logic   sv [NSQ+1];
	stage_t sd [NSQ+1];
	logic   mv [FIELD_W+1];
	stage_t md [FIELD_W+1];

	// round entry: square path starts from t, multiplicand is a or t (first round: t, or m for a multiply)
	always_comb begin
		sd[0]     = in_d;
		sd[0].act = FIRST | in_d.inv;
		sd[0].s   = in_d.t;
		sd[0].acc = '0;
		if (FIRST) begin
			sd[0].m = in_d.inv ? in_d.t : in_d.m;
		end else begin
			sd[0].m = USE_A ? in_d.a : in_d.t;
		end
	end
	assign sv[0] = in_v;

	for (genvar k = 0; k < NSQ; k++) begin : g_sq
		gf47_sq_cell u_sq (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_v   (sv[k]),
			.in_d   (sd[k]),
			.out_v  (sv[k+1]),
			.out_d  (sd[k+1])
		);
	end

	assign mv[0] = sv[NSQ];
	assign md[0] = sd[NSQ];

	for (genvar k = 0; k < FIELD_W; k++) begin : g_mul
		gf47_mul_cell #(.BIT(FIELD_W - 1 - k)) u_mul (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_v   (mv[k]),
			.in_d   (md[k]),
			.out_v  (mv[k+1]),
			.out_d  (md[k+1])
		);
	end

	always_comb begin
		out_d = md[FIELD_W];
		if (md[FIELD_W].act) begin
			out_d.t = md[FIELD_W].acc;
		end
	end
	assign out_v = mv[FIELD_W];
endmodule
`default_nettype wire

// ----- rtl/core/gf2_47_multiply_invert.sv -----
// channel  modport  payload
// req      sink     req_type, operand_a, operand_b
// res      source   field_result
//
// results pass through the cell chain and then the output buffer
// one request per cycle unless stalled: 8 rounds holding 45 squaring cells in all and
// 47 multiply-bit cells each, and a final squaring cell, all advancing together
// the whole chain stalls only while the two-entry output buffer is full
// arst_n clears stage valid bits and the output buffer
`default_nettype none
`include "gf2_47_multiply_invert_macros.svh"
module gf2_47_multiply_invert import gf47_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	gf47_req_if.sink   req,
	gf47_res_if.source res
);
	logic   en;
	logic   rv [NUM_ROUNDS+1];
	stage_t rd [NUM_ROUNDS+1];
	stage_t fin_d;
	logic   fv;
	stage_t fd;
	logic   push;
	logic   pop;
	logic [1:0] cnt_q;
	logic   wr_q;
	logic   rd_q;
	logic [FIELD_W-1:0] buf_q [2];

	assign en = (cnt_q != 2'd2);
	assign req.ready = en;

	always_comb begin
		rd[0].inv = (req.req_type == REQ_INV);
		rd[0].act = 1'b0;
		rd[0].a   = req.operand_a;
		rd[0].t   = req.operand_a;
		rd[0].s   = '0;
		rd[0].m   = req.operand_b;
		rd[0].acc = '0;
	end
	assign rv[0] = req.valid && req.ready;

	for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
		gf47_round #(
			.NSQ   (ROUND_SQ[r]),
			.USE_A (ROUND_USE_A[r]),
			.FIRST (r == 0)
		) u_round (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_v   (rv[r]),
			.in_d   (rd[r]),
			.out_v  (rv[r+1]),
			.out_d  (rd[r+1])
		);
	end

	// final squaring
	always_comb begin
		fin_d   = rd[NUM_ROUNDS];
		fin_d.s = rd[NUM_ROUNDS].t;
	end

	gf47_sq_cell u_sq_final (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (rv[NUM_ROUNDS]),
		.in_d   (fin_d),
		.out_v  (fv),
		.out_d  (fd)
	);

	assign push = fv && en;
	assign pop  = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= fd.inv ? fd.s : fd.t;
		end
	end

	assign res.valid        = (cnt_q != 2'd0);
	assign res.field_result = buf_q[rd_q];

	`GF47_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q != 2'd3)
	`GF47_ASSERT_NEXT(a_full_stall_holds, cnt_q == 2'd2 && !res.ready, cnt_q == 2'd2)
	`GF47_ASSERT_NEXT(a_push_pop_stable, push && pop, $stable(cnt_q))
	`GF47_ASSERT_NEXT(a_res_held, res.valid && !res.ready, res.valid && $stable(res.field_result))
endmodule
`default_nettype wire

// ----- dv/gf47_tb_pkg.sv -----
package gf47_tb_pkg;
	import gf47_pkg::*;

	localparam logic [46:0] FIELD_MASK = 47'h7fffffffffff;

	function automatic logic [46:0] field_times_x(input logic [46:0] v);
		logic [46:0] r;
		r = v << 1;
		if (v[46]) begin
			r = r ^ 47'h21;
		end
		return r;
	endfunction

	function automatic logic [46:0] field_product(input logic [46:0] a, input logic [46:0] b);
		logic [46:0] acc;
		acc = '0;
		for (int i = 46; i >= 0; i--) begin
			acc = field_times_x(acc);
			if (b[i]) begin
				acc = acc ^ a;
			end
		end
		return acc;
	endfunction

	function automatic logic [46:0] field_inverse(input logic [46:0] a);
		logic [46:0] base;
		logic [46:0] acc;
		logic [46:0] e;
		base = a;
		acc = 47'd1;
		e = 47'h7ffffffffffe;
		while (e != 0) begin
			if (e[0]) begin
				acc = field_product(acc, base);
			end
			base = field_product(base, base);
			e = e >> 1;
		end
		return acc;
	endfunction
endpackage

// ----- dv/gf47_checker.sv -----
module gf47_checker import gf47_pkg::*; import gf47_tb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  logic req_type,
	input  logic [46:0] operand_a,
	input  logic [46:0] operand_b,
	input  logic res_valid,
	input  logic res_ready,
	input  logic [46:0] field_result,
	output int errors,
	output int pending
);
	logic [46:0] expected_results[$];

	initial errors = 0;
	initial pending = 0;

	always @(posedge clk) begin
		logic [46:0] want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$error("field_result: unexpected result %h", field_result);
					errors <= errors + 1;
				end else begin
					want = expected_results.pop_front();
					if (want !== field_result) begin
						$error("field_result: expected %h actual %h", want, field_result);
						errors <= errors + 1;
					end
				end
			end
			if (req_valid && req_ready) begin
				if (req_kind_t'(req_type) == REQ_INV) begin
					expected_results.push_back(field_inverse(operand_a));
				end else begin
					expected_results.push_back(field_product(operand_a, operand_b));
				end
			end
		end
		pending <= expected_results.size();
	end
endmodule

// ----- dv/gf2_47_multiply_invert_tb.sv -----
module gf2_47_multiply_invert_tb;
	import gf47_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int errors;
	int pending;
	int cycles = 0;
	bit hold_off = 0;

	gf47_req_if req();
	gf47_res_if res();

	gf2_47_multiply_invert u_dut (.clk(clk), .arst_n(arst_n), .req(req), .res(res));

	gf47_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready), .req_type(req.req_type),
		.operand_a(req.operand_a), .operand_b(req.operand_b),
		.res_valid(res.valid), .res_ready(res.ready), .field_result(res.field_result),
		.errors(errors), .pending(pending)
	);

	always #1 clk = ~clk;

	initial begin
		req.valid = 0;
		req.req_type = REQ_MUL;
		req.operand_a = '0;
		req.operand_b = '0;
		res.ready = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [46:0] rand_operand();
		logic [46:0] v;
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = 47'h7fffffffffff;
			2: v = 47'd1 << $urandom_range(0, 46);
			3: v = 47'($urandom_range(0, 15));
			default: v = 47'({$urandom, $urandom});
		endcase
		return v;
	endfunction

	task automatic send(input req_kind_t kind, input logic [46:0] a, input logic [46:0] b);
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0) begin
			gap = 0;
		end
		if (gap != 0) begin
			req.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1;
		req.req_type <= kind;
		req.operand_a <= a;
		req.operand_b <= b;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// sink side with one long hold-off
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				res.ready <= 0;
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
			if (gap != 0) begin
				res.ready <= 0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1;
			@(posedge clk);
			while (!res.valid) @(posedge clk);
		end
	end

	initial begin
		logic [46:0] edge_vals[6];
		edge_vals = '{47'h0, 47'h1, 47'h7fffffffffff, 47'h400000000000, 47'h21,
			47'h555555555555};
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < 6; i++) begin
			send(REQ_MUL, edge_vals[i], edge_vals[(i + 2) % 6]);
			send(REQ_INV, edge_vals[i], edge_vals[(i + 3) % 6]);
		end
		send(REQ_MUL, 47'h7fffffffffff, 47'h7fffffffffff);
		send(REQ_MUL, 47'h400000000000, 47'h400000000000);
		send(REQ_INV, 47'h2, 47'h7fffffffffff);
		for (int n = 0; n < 1435; n++) begin
			if (n == 300) begin
				hold_off = 1;
			end
			if (n >= 300 && n < 320) begin
				req.valid <= 1;
				req.req_type <= req_kind_t'($urandom_range(0, 1));
				req.operand_a <= rand_operand();
				req.operand_b <= rand_operand();
				@(posedge clk);
				while (!req.ready) @(posedge clk);
			end else begin
				send(req_kind_t'($urandom_range(0, 1)), rand_operand(), rand_operand());
			end
		end
		req.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/gf47_pkg.sv
rtl/core/gf47_if.sv
rtl/core/gf47_sq_cell.sv
rtl/core/gf47_mul_cell.sv
rtl/core/gf47_round.sv
rtl/core/gf2_47_multiply_invert.sv
dv/gf47_tb_pkg.sv
dv/gf47_checker.sv
dv/gf2_47_multiply_invert_tb.sv
